// ===== design/bcc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

   localparam int CFG_W    = 16;
   localparam int LEVELS_W = 2;
   localparam int EVENT_W  = 2;
   localparam int EVENTS_W = 4;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd20;
   localparam logic [CFG_W-1:0] LONG_PRESS_RESET   = 16'd1000;
   localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd300;
   localparam logic             PRESSED_LEVEL_RESET = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE        = 3'd0,
      ST_DEB_PRESS   = 3'd1,
      ST_HOLD        = 3'd2,
      ST_DEB_RELEASE = 3'd3,
      ST_WAIT_DOUBLE = 3'd4,
      ST_DOUBLE_DONE = 3'd5
   } state_type;

   typedef enum logic [EVENT_W-1:0] {
      EV_NONE   = 2'd0,
      EV_SHORT  = 2'd1,
      EV_LONG   = 2'd2,
      EV_DOUBLE = 2'd3
   } event_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      REG_DEBOUNCE      = 2'd0,
      REG_LONG_PRESS    = 2'd1,
      REG_DOUBLE_CLICK  = 2'd2,
      REG_PRESSED_LEVEL = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] debounce_ticks;
      logic [CFG_W-1:0] long_press_ticks;
      logic [CFG_W-1:0] double_click_ticks;
      logic             pressed_level;
   } cfg_type;

   typedef struct packed {
      logic tick;
      logic clear;
      logic pressed;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ===== design/bcc_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_csr (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_psel,
   input  wire                              csr_penable,
   input  wire                              csr_pwrite,
   input  wire  [bcc_pkg::ADDR_W-1:0]       csr_paddr,
   input  wire  [bcc_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [bcc_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready,
   output bcc_pkg::cfg_type                 cfg
);

   bcc_pkg::cfg_type      cfg_ff;
   bcc_pkg::reg_index_type index;
   logic                  write_en;

   assign index      = bcc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks     <= bcc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks   <= bcc_pkg::LONG_PRESS_RESET;
         cfg_ff.double_click_ticks <= bcc_pkg::DOUBLE_CLICK_RESET;
         cfg_ff.pressed_level      <= bcc_pkg::PRESSED_LEVEL_RESET;
      end else if (write_en) begin
         unique case (index)
            bcc_pkg::REG_DEBOUNCE: begin
               cfg_ff.debounce_ticks <= csr_pwdata[bcc_pkg::CFG_W-1:0];
            end
            bcc_pkg::REG_LONG_PRESS: begin
               cfg_ff.long_press_ticks <= csr_pwdata[bcc_pkg::CFG_W-1:0];
            end
            bcc_pkg::REG_DOUBLE_CLICK: begin
               cfg_ff.double_click_ticks <= csr_pwdata[bcc_pkg::CFG_W-1:0];
            end
            bcc_pkg::REG_PRESSED_LEVEL: begin
               cfg_ff.pressed_level <= csr_pwdata[0];
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bcc_pkg::REG_DEBOUNCE:      csr_prdata = bcc_pkg::DATA_W'(cfg_ff.debounce_ticks);
         bcc_pkg::REG_LONG_PRESS:    csr_prdata = bcc_pkg::DATA_W'(cfg_ff.long_press_ticks);
         bcc_pkg::REG_DOUBLE_CLICK:  csr_prdata = bcc_pkg::DATA_W'(cfg_ff.double_click_ticks);
         bcc_pkg::REG_PRESSED_LEVEL: csr_prdata = bcc_pkg::DATA_W'(cfg_ff.pressed_level);
      endcase
   end

endmodule

`default_nettype wire

// ===== design/bcc_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_lane #(
   parameter int COUNT_WIDTH = 16
) (
   input  wire                        clock,
   input  wire                        reset,
   input  bcc_pkg::lane_ctrl_type     ctrl,
   input  bcc_pkg::cfg_type           cfg,
   output bcc_pkg::event_type         latched_next
);

   localparam int CMP_W = (COUNT_WIDTH > bcc_pkg::CFG_W) ? COUNT_WIDTH : bcc_pkg::CFG_W;

   bcc_pkg::state_type     state_ff, state_in;
   bcc_pkg::event_type     latched_ff, latched_in;
   logic                   fired_ff, fired_in;
   logic [COUNT_WIDTH-1:0] debounce_ff, debounce_in, debounce_inc;
   logic [COUNT_WIDTH-1:0] held_ff, held_in, held_inc;
   logic [COUNT_WIDTH-1:0] window_ff, window_in, window_inc;
   logic                   debounce_met, held_met_inc, held_met_cur, window_met;

   // saturating increments
   assign debounce_inc = (debounce_ff == '1) ? debounce_ff : debounce_ff + COUNT_WIDTH'(1);
   assign held_inc     = (held_ff == '1) ? held_ff : held_ff + COUNT_WIDTH'(1);
   assign window_inc   = (window_ff == '1) ? window_ff : window_ff + COUNT_WIDTH'(1);

   assign debounce_met = CMP_W'(debounce_inc) >= CMP_W'(cfg.debounce_ticks);
   assign held_met_inc = CMP_W'(held_inc) >= CMP_W'(cfg.long_press_ticks);
   assign held_met_cur = CMP_W'(held_ff) >= CMP_W'(cfg.long_press_ticks);
   assign window_met   = CMP_W'(window_inc) >= CMP_W'(cfg.double_click_ticks);

   assign latched_next = latched_in;

   always_comb begin
      state_in = state_ff;
      if (ctrl.tick) begin
         unique case (state_ff)
            bcc_pkg::ST_IDLE: begin
               if (ctrl.pressed) state_in = bcc_pkg::ST_DEB_PRESS;
            end
            bcc_pkg::ST_DEB_PRESS: begin
               if (debounce_met) begin
                  state_in = ctrl.pressed ? bcc_pkg::ST_HOLD : bcc_pkg::ST_IDLE;
               end
            end
            bcc_pkg::ST_HOLD: begin
               if (!ctrl.pressed) state_in = bcc_pkg::ST_DEB_RELEASE;
            end
            bcc_pkg::ST_DEB_RELEASE: begin
               if (debounce_met) begin
                  if (ctrl.pressed) begin
                     state_in = bcc_pkg::ST_HOLD;
                  end else if (held_met_cur || fired_ff) begin
                     state_in = bcc_pkg::ST_IDLE;
                  end else begin
                     state_in = bcc_pkg::ST_WAIT_DOUBLE;
                  end
               end
            end
            bcc_pkg::ST_WAIT_DOUBLE: begin
               if (ctrl.pressed) begin
                  if (debounce_met && !fired_ff) state_in = bcc_pkg::ST_DOUBLE_DONE;
               end else if (window_met && !fired_ff) begin
                  state_in = bcc_pkg::ST_IDLE;
               end
            end
            bcc_pkg::ST_DOUBLE_DONE: begin
               if (!ctrl.pressed && debounce_met) state_in = bcc_pkg::ST_IDLE;
            end
            default: begin
               state_in = bcc_pkg::ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      debounce_in = debounce_ff;
      held_in     = held_ff;
      window_in   = window_ff;
      fired_in    = fired_ff;
      latched_in  = latched_ff;
      if (ctrl.clear) begin
         latched_in = bcc_pkg::EV_NONE;
      end else if (ctrl.tick) begin
         unique case (state_ff)
            bcc_pkg::ST_IDLE: begin
               fired_in  = 1'b0;
               window_in = '0;
               if (ctrl.pressed) debounce_in = '0;
            end
            bcc_pkg::ST_DEB_PRESS: begin
               debounce_in = debounce_inc;
               if (debounce_met && ctrl.pressed) begin
                  debounce_in = '0;
                  held_in     = '0;
               end
            end
            bcc_pkg::ST_HOLD: begin
               if (ctrl.pressed) begin
                  held_in = held_inc;
                  if (held_met_inc && !fired_ff) begin
                     latched_in = bcc_pkg::EV_LONG;
                     fired_in   = 1'b1;
                  end
               end else begin
                  debounce_in = '0;
               end
            end
            bcc_pkg::ST_DEB_RELEASE: begin
               debounce_in = debounce_inc;
               if (debounce_met && !ctrl.pressed && !(held_met_cur || fired_ff)) begin
                  window_in = '0;
               end
            end
            bcc_pkg::ST_WAIT_DOUBLE: begin
               window_in = window_inc;
               if (ctrl.pressed) begin
                  debounce_in = debounce_inc;
                  if (debounce_met && !fired_ff) begin
                     latched_in  = bcc_pkg::EV_DOUBLE;
                     fired_in    = 1'b1;
                     debounce_in = '0;
                  end
               end else if (window_met && !fired_ff) begin
                  latched_in = bcc_pkg::EV_SHORT;
               end
            end
            bcc_pkg::ST_DOUBLE_DONE: begin
               if (!ctrl.pressed) begin
                  debounce_in = debounce_met ? '0 : debounce_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bcc_pkg::ST_IDLE;
         latched_ff  <= bcc_pkg::EV_NONE;
         fired_ff    <= 1'b0;
         debounce_ff <= '0;
         held_ff     <= '0;
         window_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         latched_ff  <= latched_in;
         fired_ff    <= fired_in;
         debounce_ff <= debounce_in;
         held_ff     <= held_in;
         window_ff   <= window_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/bcc_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bcc_merge #(
   parameter int NUM_BUTTONS = 2
) (
   input  wire                                              clock,
   input  wire                                              reset,
   input  wire  [NUM_BUTTONS-1:0][bcc_pkg::EVENT_W-1:0]     lane_latched,
   input  wire                                              req_valid,
   output logic                                             req_ready,
   output logic                                             accept,
   output logic                                             rsp_valid,
   input  wire                                              rsp_ready,
   output logic [bcc_pkg::EVENTS_W-1:0]                     rsp_events
);

   localparam int SLOTS = bcc_pkg::EVENTS_W / bcc_pkg::EVENT_W;
   localparam int SHOWN = (NUM_BUTTONS < SLOTS) ? NUM_BUTTONS : SLOTS;

   logic                          rsp_valid_ff;
   logic [bcc_pkg::EVENTS_W-1:0]  rsp_events_ff;
   logic [bcc_pkg::EVENTS_W-1:0]  packed_events;

   always_comb begin
      packed_events = '0;
      for (int i = 0; i < SHOWN; i++) begin
         packed_events[i*bcc_pkg::EVENT_W +: bcc_pkg::EVENT_W] = lane_latched[i];
      end
   end

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_events = rsp_events_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_events_ff <= packed_events;
      end
   end

endmodule

`default_nettype wire

// ===== design/button_click_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Classifies button presses as short, long or double clicks. Every button has
// its own debounce and click state machine, all advanced together by a tick
// item; a clear item erases one button's latched event. The result of each
// item, the packed latched events, is registered and shown the cycle after
// the transfer; a new item is taken every cycle as long as the result
// register is empty or being drained. The per-button state update is
// combinational and feeds the result register directly.

module button_click_classifier #(
   parameter int NUM_BUTTONS = 2,
   parameter int COUNT_WIDTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_cmd,
   input  wire  [bcc_pkg::LEVELS_W-1:0]      req_levels,
   input  wire                               req_clear_button,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [bcc_pkg::EVENTS_W-1:0]      rsp_events,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [bcc_pkg::ADDR_W-1:0]        csr_paddr,
   input  wire  [bcc_pkg::DATA_W-1:0]        csr_pwdata,
   output logic [bcc_pkg::DATA_W-1:0]        csr_prdata,
   output logic                              csr_pready
);

   bcc_pkg::cfg_type                             cfg;
   logic                                         accept;
   logic [NUM_BUTTONS-1:0][bcc_pkg::EVENT_W-1:0] lane_latched;

   bcc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
      bcc_pkg::lane_ctrl_type ctrl;
      bcc_pkg::event_type     latched_next;
      logic                   level;

      if (i < bcc_pkg::LEVELS_W) begin : g_pin
         assign level = req_levels[i];
      end else begin : g_nopin
         assign level = 1'b0;
      end

      assign ctrl.tick    = accept && (req_cmd == bcc_pkg::CMD_TICK);
      assign ctrl.clear   = accept && (req_cmd == bcc_pkg::CMD_CLEAR)
                            && (32'(req_clear_button) == i);
      assign ctrl.pressed = (level == cfg.pressed_level);

      bcc_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .cfg          (cfg),
         .latched_next (latched_next)
      );

      assign lane_latched[i] = latched_next;
   end

   bcc_merge #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .lane_latched (lane_latched),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .accept       (accept),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_events   (rsp_events)
   );

   a_transfer_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("no result after input transfer");

   a_no_take_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input taken while result is blocked");

   a_clear_button0: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == bcc_pkg::CMD_CLEAR) && !req_clear_button)
      |=> (rsp_events[1:0] == bcc_pkg::EV_NONE))
      else $error("clear did not erase button event");

endmodule

`default_nettype wire

// ===== sim/click_event_checker.sv =====
`timescale 1ns / 1ps

module click_event_checker
   import bcc_pkg::*;
#(
   parameter int NUM_BUTTONS = 2,
   parameter int COUNT_WIDTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_ready,
   input  wire                  req_cmd,
   input  wire [LEVELS_W-1:0]   req_levels,
   input  wire                  req_clear_button,
   input  wire                  rsp_valid,
   input  wire                  rsp_ready,
   input  wire [EVENTS_W-1:0]   rsp_events,
   input  wire                  csr_psel,
   input  wire                  csr_penable,
   input  wire                  csr_pwrite,
   input  wire [ADDR_W-1:0]     csr_paddr,
   input  wire [DATA_W-1:0]     csr_pwdata,
   input  wire [DATA_W-1:0]     csr_prdata,
   input  wire                  csr_pready,
   output int                   fail_count,
   output int                   pending
);

   cfg_type                cfg;
   logic [2:0]             btn_state [NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] deb_cnt   [NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] hold_cnt  [NUM_BUTTONS];
   logic [COUNT_WIDTH-1:0] win_cnt   [NUM_BUTTONS];
   logic                   fired     [NUM_BUTTONS];
   event_type              latched   [NUM_BUTTONS];
   logic [EVENTS_W-1:0]    expected_events [$];

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic void clear_model();
      cfg.debounce_ticks     = DEBOUNCE_RESET;
      cfg.long_press_ticks   = LONG_PRESS_RESET;
      cfg.double_click_ticks = DOUBLE_CLICK_RESET;
      cfg.pressed_level      = PRESSED_LEVEL_RESET;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         btn_state[b] = ST_IDLE;
         deb_cnt[b]   = '0;
         hold_cnt[b]  = '0;
         win_cnt[b]   = '0;
         fired[b]     = 1'b0;
         latched[b]   = EV_NONE;
      end
   endfunction

   function automatic void step_button(input int b, input logic pressed);
      case (btn_state[b])
         ST_IDLE: begin
            fired[b]   = 1'b0;
            win_cnt[b] = '0;
            if (pressed) begin
               btn_state[b] = ST_DEB_PRESS;
               deb_cnt[b]   = '0;
            end
         end
         ST_DEB_PRESS: begin
            deb_cnt[b] = sat_inc(deb_cnt[b]);
            if (deb_cnt[b] >= cfg.debounce_ticks) begin
               if (pressed) begin
                  btn_state[b] = ST_HOLD;
                  deb_cnt[b]   = '0;
                  hold_cnt[b]  = '0;
               end else begin
                  btn_state[b] = ST_IDLE;
               end
            end
         end
         ST_HOLD: begin
            if (pressed) begin
               hold_cnt[b] = sat_inc(hold_cnt[b]);
               if (hold_cnt[b] >= cfg.long_press_ticks && !fired[b]) begin
                  latched[b] = EV_LONG;
                  fired[b]   = 1'b1;
               end
            end else begin
               btn_state[b] = ST_DEB_RELEASE;
               deb_cnt[b]   = '0;
            end
         end
         ST_DEB_RELEASE: begin
            deb_cnt[b] = sat_inc(deb_cnt[b]);
            if (deb_cnt[b] >= cfg.debounce_ticks) begin
               if (!pressed) begin
                  if (hold_cnt[b] >= cfg.long_press_ticks || fired[b]) begin
                     btn_state[b] = ST_IDLE;
                  end else begin
                     btn_state[b] = ST_WAIT_DOUBLE;
                     win_cnt[b]   = '0;
                  end
               end else begin
                  btn_state[b] = ST_HOLD;
               end
            end
         end
         ST_WAIT_DOUBLE: begin
            // debounce count carries over from the release on purpose
            win_cnt[b] = sat_inc(win_cnt[b]);
            if (pressed) begin
               deb_cnt[b] = sat_inc(deb_cnt[b]);
               if (deb_cnt[b] >= cfg.debounce_ticks && !fired[b]) begin
                  latched[b]   = EV_DOUBLE;
                  fired[b]     = 1'b1;
                  btn_state[b] = ST_DOUBLE_DONE;
                  deb_cnt[b]   = '0;
               end
            end else if (win_cnt[b] >= cfg.double_click_ticks && !fired[b]) begin
               latched[b]   = EV_SHORT;
               btn_state[b] = ST_IDLE;
            end
         end
         ST_DOUBLE_DONE: begin
            if (!pressed) begin
               deb_cnt[b] = sat_inc(deb_cnt[b]);
               if (deb_cnt[b] >= cfg.debounce_ticks) begin
                  btn_state[b] = ST_IDLE;
                  deb_cnt[b]   = '0;
               end
            end
         end
         default: begin
            btn_state[b] = ST_IDLE;
         end
      endcase
   endfunction

   function automatic logic [EVENTS_W-1:0] packed_events();
      logic [EVENTS_W-1:0] v;
      v = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) v[2*b +: EVENT_W] = latched[b];
      return v;
   endfunction

   function automatic logic [DATA_W-1:0] reg_value(input reg_index_type idx);
      case (idx)
         REG_DEBOUNCE:     return DATA_W'(cfg.debounce_ticks);
         REG_LONG_PRESS:   return DATA_W'(cfg.long_press_ticks);
         REG_DOUBLE_CLICK: return DATA_W'(cfg.double_click_ticks);
         default:          return DATA_W'(cfg.pressed_level);
      endcase
   endfunction

   function automatic void write_reg(input reg_index_type idx, input logic [DATA_W-1:0] v);
      case (idx)
         REG_DEBOUNCE:     cfg.debounce_ticks     = v[CFG_W-1:0];
         REG_LONG_PRESS:   cfg.long_press_ticks   = v[CFG_W-1:0];
         REG_DOUBLE_CLICK: cfg.double_click_ticks = v[CFG_W-1:0];
         default:          cfg.pressed_level      = v[0];
      endcase
   endfunction

   always @(posedge clock) begin
      logic [EVENTS_W-1:0] want;
      reg_index_type       idx;
      if (reset) begin
         clear_model();
         expected_events.delete();
      end else begin
         idx = reg_index_type'(csr_paddr[3:2]);
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               write_reg(idx, csr_pwdata);
            end else if (csr_prdata !== reg_value(idx)) begin
               $error("prdata mismatch at register %0d: expected %0h, actual %0h",
                      idx, reg_value(idx), csr_prdata);
               fail_count++;
            end
         end
         // request first, so a same-edge response still finds its entry
         if (req_valid && req_ready) begin
            if (req_cmd == CMD_TICK) begin
               for (int b = 0; b < NUM_BUTTONS; b++)
                  step_button(b, req_levels[b] == cfg.pressed_level);
            end else if (req_clear_button < NUM_BUTTONS) begin
               latched[req_clear_button] = EV_NONE;
            end
            expected_events.push_back(packed_events());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected rsp transfer: events %0h", rsp_events);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_events !== want) begin
                  $error("events mismatch: expected %0h, actual %0h", want, rsp_events);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_events.size();
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import bcc_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam int SPAN_CAP     = 400;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_cmd          = 1'b0;
   logic [LEVELS_W-1:0]  req_levels       = '0;
   logic                 req_clear_button = 1'b0;
   logic                 rsp_ready        = 1'b0;
   logic                 csr_psel         = 1'b0;
   logic                 csr_penable      = 1'b0;
   logic                 csr_pwrite       = 1'b0;
   logic [ADDR_W-1:0]    csr_paddr        = '0;
   logic [DATA_W-1:0]    csr_pwdata       = '0;
   wire                  req_ready;
   wire                  rsp_valid;
   wire  [EVENTS_W-1:0]  rsp_events;
   wire  [DATA_W-1:0]    csr_prdata;
   wire                  csr_pready;
   int                   fail_count;
   int                   pending;
   int                   cycle_count = 0;
   bit                   quiet = 1'b0;

   // current settings, used to time the press and release spans
   int                   deb_t  = DEBOUNCE_RESET;
   int                   long_t = LONG_PRESS_RESET;
   int                   dbl_t  = DOUBLE_CLICK_RESET;
   logic                 plevel = PRESSED_LEVEL_RESET;
   bit                   btn_down [2];
   int                   btn_left [2];

   button_click_classifier i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_levels       (req_levels),
      .req_clear_button (req_clear_button),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_events       (rsp_events),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   click_event_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_levels       (req_levels),
      .req_clear_button (req_clear_button),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_events       (rsp_events),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ready <= quiet || ($urandom_range(99) >= 31);
   end

   task automatic send(input cmd_type cmd, input logic [LEVELS_W-1:0] lv, input logic clr);
      while (!quiet && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_levels       <= lv;
      req_clear_button <= clr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_cycle(input logic wr, input reg_index_type idx,
                            input logic [DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic read_back();
      for (int i = 0; i < 4; i++) csr_cycle(1'b0, reg_index_type'(i), '0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input int d, input int l, input int w, input logic p);
      csr_cycle(1'b1, REG_DEBOUNCE, DATA_W'(d));
      csr_cycle(1'b1, REG_LONG_PRESS, DATA_W'(l));
      csr_cycle(1'b1, REG_DOUBLE_CLICK, DATA_W'(w));
      csr_cycle(1'b1, REG_PRESSED_LEVEL, DATA_W'(p));
      read_back();
      deb_t  = d;
      long_t = l;
      dbl_t  = w;
      plevel = p;
   endtask

   function automatic int pick_span();
      int r;
      int s;
      r = $urandom_range(99);
      if (r < 15)      s = $urandom_range((deb_t > 1) ? deb_t - 1 : 1, 1);
      else if (r < 45) s = deb_t + $urandom_range(4);
      else if (r < 65) s = long_t - 2 + $urandom_range(4);
      else if (r < 90) s = deb_t + dbl_t - 2 + $urandom_range(4);
      else             s = $urandom_range(60, 1);
      if (s < 1) s = 1;
      if (s > SPAN_CAP) s = SPAN_CAP;
      return s;
   endfunction

   // press and release spans per button, with clears and glitches mixed in
   task automatic run_clicks(input int count);
      logic [LEVELS_W-1:0] lv;
      int                  r;
      for (int b = 0; b < 2; b++) begin
         btn_down[b] = 1'b0;
         btn_left[b] = $urandom_range(3);
      end
      repeat (count) begin
         r = $urandom_range(99);
         if (r < 8) begin
            send(CMD_CLEAR, LEVELS_W'($urandom_range(3)), 1'($urandom_range(1)));
         end else begin
            for (int b = 0; b < 2; b++) begin
               if (btn_left[b] == 0) begin
                  btn_down[b] = !btn_down[b];
                  btn_left[b] = pick_span();
               end
               btn_left[b]--;
               lv[b] = btn_down[b] ? plevel : !plevel;
            end
            if (r < 12) lv[$urandom_range(1)] ^= 1'b1;
            send(CMD_TICK, lv, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      read_back();

      send(CMD_TICK, 2'b11, 1'b0);
      send(CMD_TICK, 2'b00, 1'b1);
      send(CMD_TICK, 2'b01, 1'b0);
      send(CMD_TICK, 2'b10, 1'b1);
      send(CMD_CLEAR, 2'b11, 1'b0);
      send(CMD_CLEAR, 2'b00, 1'b1);
      send(CMD_TICK, 2'b11, 1'b1);
      run_clicks(200);

      settle();
      configure(0, 0, 0, 1'b1);
      run_clicks(200);
      settle();
      configure(1, 1, 1, 1'b0);
      run_clicks(200);
      settle();
      configure(2, 8, 5, 1'b1);
      run_clicks(200);
      settle();
      quiet = 1'b1;
      configure(3, 20, 12, 1'b0);
      run_clicks(200);
      settle();
      quiet = 1'b0;
      configure(5, 30, 25, 1'b1);
      run_clicks(200);
      settle();
      configure(1, 12, 40, 1'b0);
      run_clicks(200);
      settle();
      configure(4, 65535, 6, 1'b1);
      run_clicks(200);
      settle();
      configure(2, 10, 65535, 1'b0);
      run_clicks(200);
      settle();

      repeat (5) @(negedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bcc_pkg.sv
design/bcc_csr.sv
design/bcc_lane.sv
design/bcc_merge.sv
design/button_click_classifier.sv
sim/click_event_checker.sv
sim/tb.sv
